FILE: design/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes on the op field
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_SEND  = 3'd3;
  localparam logic [2:0] OP_WACK  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
  localparam logic [9:0]  ACK_TIMEOUT_RESET = 10'd250;

  localparam int DELAY_WIDTH_DEF = 16;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [9:0]  ack_timeout;
  } i2cm_cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
  } i2cm_res_t;

endpackage

FILE: design/i2cm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus phase sequencer: holds phase, counters and shift register, advances
// one tick per enabled cycle and presents the result of that tick.
// ----------------------------------------------------------------------------
module i2cm_seq
  import i2cm_pkg::*;
#(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step_en,
  input  logic [2:0] op,
  input  logic [7:0] tx_byte,
  input  logic      send_ack,
  input  logic      sda_in,
  input  i2cm_cfg_t cfg,
  output i2cm_res_t res_next
);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_STOP_A    = 4'd3,
    PH_STOP_B    = 4'd4,
    PH_WACK_A    = 4'd5,
    PH_WACK_B    = 4'd6,
    PH_WACK_POLL = 4'd7,
    PH_SEND_LOW  = 4'd8,
    PH_SEND_HIGH = 4'd9,
    PH_SEND_TAIL = 4'd10,
    PH_READ_LOW  = 4'd11,
    PH_READ_HIGH = 4'd12,
    PH_ACK_LOW   = 4'd13,
    PH_ACK_HIGH  = 4'd14
  } phase_t;

  phase_t                 phase, phase_next;
  logic [3:0]             bit_count, bit_count_next;
  logic [7:0]             shift_reg, shift_reg_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_count_next;
  logic [9:0]             wait_count, wait_count_next;
  logic                   scl_drive, scl_drive_next;
  logic                   sda_drive, sda_drive_next;
  logic                   ack_flag, ack_flag_next;
  logic                   ack_choice, ack_choice_next;
  logic [7:0]             rx_data, rx_data_next;

  logic [DELAY_WIDTH-1:0] hpt_trunc;
  logic [DELAY_WIDTH-1:0] dly_len;
  logic [DELAY_WIDTH-1:0] cnt_inc;
  logic [DELAY_WIDTH-1:0] cnt_after;
  logic                   expired;
  logic [3:0]             bc_inc;
  logic                   done;

  // a zero delay register acts the same as a value of 1
  assign hpt_trunc = DELAY_WIDTH'(cfg.half_period_ticks);
  assign dly_len   = (hpt_trunc == '0) ? DELAY_WIDTH'(1) : hpt_trunc;
  assign cnt_inc   = delay_count + DELAY_WIDTH'(1);
  assign expired   = (cnt_inc >= dly_len);
  assign cnt_after = expired ? '0 : cnt_inc;
  assign bc_inc    = bit_count + 4'd1;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    wait_count_next  = wait_count;
    scl_drive_next   = scl_drive;
    sda_drive_next   = sda_drive;
    ack_flag_next    = ack_flag;
    ack_choice_next  = ack_choice;
    rx_data_next     = rx_data;
    done             = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        unique case (op)
          OP_START: begin
            sda_drive_next   = 1'b1;
            scl_drive_next   = 1'b1;
            phase_next       = PH_START_A;
            delay_count_next = '0;
          end
          OP_STOP: begin
            scl_drive_next   = 1'b0;
            sda_drive_next   = 1'b0;
            phase_next       = PH_STOP_A;
            delay_count_next = '0;
          end
          OP_SEND: begin
            scl_drive_next   = 1'b0;
            bit_count_next   = '0;
            sda_drive_next   = tx_byte[7];
            shift_reg_next   = {tx_byte[6:0], 1'b0};
            phase_next       = PH_SEND_LOW;
            delay_count_next = '0;
          end
          OP_WACK: begin
            sda_drive_next   = 1'b1;
            phase_next       = PH_WACK_A;
            delay_count_next = '0;
          end
          OP_READ: begin
            ack_choice_next  = send_ack;
            sda_drive_next   = 1'b1;
            scl_drive_next   = 1'b0;
            bit_count_next   = '0;
            shift_reg_next   = '0;
            phase_next       = PH_READ_LOW;
            delay_count_next = '0;
          end
          default: begin
          end
        endcase
      end
      PH_START_A: begin
        delay_count_next = cnt_after;
        if (expired) begin
          sda_drive_next = 1'b0;
          phase_next     = PH_START_B;
        end
      end
      PH_START_B: begin
        delay_count_next = cnt_after;
        if (expired) begin
          scl_drive_next = 1'b0;
          done           = 1'b1;
        end
      end
      PH_STOP_A: begin
        delay_count_next = cnt_after;
        if (expired) begin
          scl_drive_next = 1'b1;
          sda_drive_next = 1'b1;
          phase_next     = PH_STOP_B;
        end
      end
      PH_STOP_B: begin
        delay_count_next = cnt_after;
        done             = expired;
      end
      PH_WACK_A: begin
        delay_count_next = cnt_after;
        if (expired) begin
          scl_drive_next = 1'b1;
          phase_next     = PH_WACK_B;
        end
      end
      PH_WACK_B: begin
        delay_count_next = cnt_after;
        if (expired) begin
          wait_count_next = '0;
          phase_next      = PH_WACK_POLL;
        end
      end
      PH_WACK_POLL: begin
        if (!sda_in) begin
          scl_drive_next = 1'b0;
          ack_flag_next  = 1'b1;
          done           = 1'b1;
        end else if (wait_count >= cfg.ack_timeout) begin
          // no acknowledge: fail and close with a stop
          ack_flag_next    = 1'b0;
          scl_drive_next   = 1'b0;
          sda_drive_next   = 1'b0;
          phase_next       = PH_STOP_A;
          delay_count_next = '0;
        end else begin
          wait_count_next = wait_count + 10'd1;
        end
      end
      PH_SEND_LOW: begin
        delay_count_next = cnt_after;
        if (expired) begin
          scl_drive_next = 1'b1;
          phase_next     = PH_SEND_HIGH;
        end
      end
      PH_SEND_HIGH: begin
        delay_count_next = cnt_after;
        if (expired) begin
          scl_drive_next = 1'b0;
          phase_next     = PH_SEND_TAIL;
        end
      end
      PH_SEND_TAIL: begin
        delay_count_next = cnt_after;
        if (expired) begin
          bit_count_next = bc_inc;
          if (bc_inc >= BITS_PER_BYTE) begin
            done = 1'b1;
          end else begin
            sda_drive_next = shift_reg[7];
            shift_reg_next = {shift_reg[6:0], 1'b0};
            phase_next     = PH_SEND_LOW;
          end
        end
      end
      PH_READ_LOW: begin
        delay_count_next = cnt_after;
        if (expired) begin
          scl_drive_next = 1'b1;
          shift_reg_next = {shift_reg[6:0], sda_in};
          phase_next     = PH_READ_HIGH;
        end
      end
      PH_READ_HIGH: begin
        delay_count_next = cnt_after;
        if (expired) begin
          bit_count_next = bc_inc;
          scl_drive_next = 1'b0;
          if (bc_inc >= BITS_PER_BYTE) begin
            rx_data_next   = shift_reg;
            sda_drive_next = !ack_choice;
            phase_next     = PH_ACK_LOW;
          end else begin
            phase_next = PH_READ_LOW;
          end
        end
      end
      PH_ACK_LOW: begin
        delay_count_next = cnt_after;
        if (expired) begin
          scl_drive_next = 1'b1;
          phase_next     = PH_ACK_HIGH;
        end
      end
      PH_ACK_HIGH: begin
        delay_count_next = cnt_after;
        if (expired) begin
          scl_drive_next = 1'b0;
          done           = 1'b1;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        delay_count_next = '0;
      end
    endcase

    if (done) begin
      phase_next       = PH_IDLE;
      delay_count_next = '0;
    end
  end

  assign res_next.scl_level = scl_drive_next;
  assign res_next.sda_level = sda_drive_next;
  assign res_next.busy_res  = (phase_next != PH_IDLE);
  assign res_next.done_res  = done;
  assign res_next.rx_byte   = rx_data_next;
  assign res_next.ack_ok    = ack_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      delay_count <= '0;
      wait_count  <= '0;
      scl_drive   <= 1'b1;
      sda_drive   <= 1'b1;
      ack_flag    <= 1'b0;
      ack_choice  <= 1'b0;
      rx_data     <= '0;
    end else if (step_en) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      wait_count  <= wait_count_next;
      scl_drive   <= scl_drive_next;
      sda_drive   <= sda_drive_next;
      ack_flag    <= ack_flag_next;
      ack_choice  <= ack_choice_next;
      rx_data     <= rx_data_next;
    end
  end

  a_idle_delay_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (delay_count == '0))
    else $error("delay counter not cleared in idle");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BITS_PER_BYTE)
    else $error("bit count beyond one byte");

  a_ack_seen: assert property (@(posedge clk) disable iff (rst)
    (step_en && phase == PH_WACK_POLL && !sda_in) |=> (ack_flag && phase == PH_IDLE))
    else $error("acknowledge not recorded");

endmodule

FILE: design/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master that sequences the open-drain SCL and SDA lines, one tick per
// input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item per bus tick, carrying the
//   sampled SDA level and an optional command (op, tx_byte, send_ack).
//   Commands are taken only while idle; otherwise they are ignored.
//   Output channel (out_valid / out_stall): one result item per input item
//   with the line drives, busy, done pulse, last read byte and ack status.
//   Config port: cfg_we writes cfg_data to register cfg_index
//   (0 half_period_ticks, 1 ack_timeout). Write only while idle.
// Timing:
//   Two-register pipeline: input register, then sequencer step into the
//   result register. An accepted item waits in the input register until the
//   result register is free, and then its result is registered there.
//   Throughput is one item per cycle while out_stall is low; the sequencer's
//   state update is a single pass of logic per tick.
// Reset:
//   Both lines released, phase idle, counters and status cleared, config
//   registers back to 5 and 250.
// Stall:
//   A stalled result holds in the output register; the input register keeps
//   its item and in_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
  import i2cm_pkg::*;
#(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,

  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             op,
  input  logic [7:0]             tx_byte,
  input  logic                   send_ack,
  input  logic                   sda_in,

  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   scl_level,
  output logic                   sda_level,
  output logic                   busy_res,
  output logic                   done_res,
  output logic [7:0]             rx_byte,
  output logic                   ack_ok
);

  i2cm_cfg_t  cfg;

  // input register
  logic       s1_valid;
  logic [2:0] s1_op;
  logic [7:0] s1_tx_byte;
  logic       s1_send_ack;
  logic       s1_sda_in;

  // result register
  i2cm_res_t  res;
  i2cm_res_t  res_next;

  logic       out_free;   // result register can take a new item
  logic       step_en;    // sequencer advances one tick
  logic       s1_load;

  assign out_free = !out_valid || !out_stall;
  assign step_en  = s1_valid && out_free;
  assign s1_load  = !s1_valid || out_free;
  assign in_stall = !s1_load;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HALF_PERIOD_RESET;
      cfg.ack_timeout       <= ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data;
        CFG_ACK_TIMEOUT: cfg.ack_timeout       <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_op       <= op;
      s1_tx_byte  <= tx_byte;
      s1_send_ack <= send_ack;
      s1_sda_in   <= sda_in;
    end
  end

  i2cm_seq #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .step_en  (step_en),
    .op       (s1_op),
    .tx_byte  (s1_tx_byte),
    .send_ack (s1_send_ack),
    .sda_in   (s1_sda_in),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res <= res_next;
    end
  end

  assign scl_level = res.scl_level;
  assign sda_level = res.sda_level;
  assign busy_res  = res.busy_res;
  assign done_res  = res.done_res;
  assign rx_byte   = res.rx_byte;
  assign ack_ok    = res.ack_ok;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done reported while still busy");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |=> s1_valid)
    else $error("pending item dropped under stall");

  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    step_en |=> out_valid)
    else $error("sequencer step without a result");

endmodule
